// ===== rtl/heading_error_to_target_unit_defines.svh =====
// assertion macros shared by the checker of the heading error unit
// needs clk and rst_n in the scope where a macro is used
`ifndef HEADING_ERROR_TO_TARGET_UNIT_DEFINES_SVH
`define HEADING_ERROR_TO_TARGET_UNIT_DEFINES_SVH

// implication in the same cycle
`define HETT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading error unit: check failed");

// implication in the next cycle
`define HETT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading error unit: check failed");

`endif

// ===== rtl/hett_pkg.sv =====
// shared types, constants and the arctangent table of the heading error unit
// no dependencies
package hett_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int TAB_LEN             = 24;

    // cordic datapath widths
    localparam int CW = 44;   // x, y after normalization plus growth
    localparam int ZW = 35;   // angle accumulator, q30 radians
    localparam int MW = 41;   // magnitude used for normalization

    typedef logic signed [CW-1:0] cord_t;
    typedef logic signed [ZW-1:0] zang_t;
    typedef logic signed [ZW:0]   diff_t;

    localparam zang_t PI_Q30     = 35'sd3373259426;
    localparam diff_t PI_DIFF    = 36'sd3373259426;
    localparam diff_t TWO_PI_DIFF = 36'sd6746518852;

    localparam logic [14:0] MAX_ERR_RESET = 15'd819;
    localparam logic [14:0] OUT_MAX       = 15'd32767;
    localparam int          COIN_SUM_MAX  = 42;
    localparam int          DEG_MAG_LIM   = 26844;
    localparam logic [32:0] DEG_SUM_MAX   = 33'd720575940;

    typedef struct packed {
        logic coin;
        logic degen;
    } hett_flags_t;

    // atan(2^-i) in q30, truncated
    function automatic logic [30:0] atan_q30(input int idx);
        logic [30:0] v;
        case (idx)
            0:  v = 31'd843314856;
            1:  v = 31'd497837829;
            2:  v = 31'd263043836;
            3:  v = 31'd133525158;
            4:  v = 31'd67021686;
            5:  v = 31'd33543515;
            6:  v = 31'd16775850;
            7:  v = 31'd8388437;
            8:  v = 31'd4194282;
            9:  v = 31'd2097149;
            10: v = 31'd1048575;
            11: v = 31'd524287;
            12: v = 31'd262143;
            13: v = 31'd131071;
            14: v = 31'd65535;
            15: v = 31'd32767;
            16: v = 31'd16383;
            17: v = 31'd8191;
            18: v = 31'd4095;
            19: v = 31'd2047;
            20: v = 31'd1023;
            21: v = 31'd511;
            22: v = 31'd255;
            23: v = 31'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/hett_if.sv =====
// channel interfaces of the heading error unit: input word, result word, config write
// depends on nothing
interface hett_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, pos_x, pos_y, target_x, target_y,
                    quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, pos_x, pos_y, target_x, target_y,
                    quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface hett_result_if;
    logic        valid;
    logic        ready;
    logic [14:0] yaw_error;
    logic        exceeds_limit;
    logic        target_coincident;
    logic        heading_degenerate;

    modport source (output valid, yaw_error, exceeds_limit, target_coincident,
                    heading_degenerate, input ready);
    modport sink   (input valid, yaw_error, exceeds_limit, target_coincident,
                    heading_degenerate, output ready);
endinterface

interface hett_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/hett_prep.sv =====
// front end: target offset, flattened forward axis and the coincident-target test
// depends on hett_pkg
module hett_prep (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic signed [32:0] dx,
    output logic signed [32:0] dy,
    output logic signed [34:0] fx,
    output logic signed [34:0] fy,
    output logic               coin
);
    import hett_pkg::*;

    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [31:0] pxy_reg, pwz_reg, pxx_reg, pzz_reg;
    logic signed [32:0] dx2_reg, dy2_reg;
    logic signed [34:0] fx_reg, fy_reg;
    logic               coin_reg;

    logic signed [34:0] cross_next, sq_next, fx_next, fy_next;
    logic signed [3:0]  dx4, dy4;
    logic signed [7:0]  dxx, dyy;
    logic               coin_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= $signed({target_x[31], target_x}) - $signed({pos_x[31], pos_x});
            dy1_reg <= $signed({target_y[31], target_y}) - $signed({pos_y[31], pos_y});
            pxy_reg <= quat_x * quat_y;
            pwz_reg <= quat_w * quat_z;
            pxx_reg <= quat_x * quat_x;
            pzz_reg <= quat_z * quat_z;
        end
    end

    always_comb
    begin
        cross_next = 35'(pxy_reg) - 35'(pwz_reg);
        sq_next    = 35'(pxx_reg) + 35'(pzz_reg);
        fx_next    = cross_next <<< 1;
        fy_next    = 35'sd268435456 - (sq_next <<< 1);
        // only values below 7 in magnitude can be coincident, low bits suffice
        dx4        = dx1_reg[3:0];
        dy4        = dy1_reg[3:0];
        dxx        = dx4 * dx4;
        dyy        = dy4 * dy4;
        coin_next  = (dx1_reg > -33'sd7) && (dx1_reg < 33'sd7) &&
                     (dy1_reg > -33'sd7) && (dy1_reg < 33'sd7) &&
                     ((9'(dxx) + 9'(dyy)) <= 9'(COIN_SUM_MAX));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            fx_reg   <= fx_next;
            fy_reg   <= fy_next;
            coin_reg <= coin_next;
        end
    end

    assign dx   = dx2_reg;
    assign dy   = dy2_reg;
    assign fx   = fx_reg;
    assign fy   = fy_reg;
    assign coin = coin_reg;

endmodule

// ===== rtl/hett_degen.sv =====
// two-stage test for a forward axis too short to give a heading
// depends on hett_pkg
module hett_degen (
    input  logic               clk,
    input  logic               en,
    input  logic signed [34:0] fx,
    input  logic signed [34:0] fy,
    output logic               degen
);
    import hett_pkg::*;

    logic               small_reg;
    logic signed [31:0] sqx_reg, sqy_reg;
    logic               degen_reg;
    logic signed [15:0] fx16, fy16;

    assign fx16 = fx[15:0];
    assign fy16 = fy[15:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            small_reg <= (fx > -35'(DEG_MAG_LIM)) && (fx < 35'(DEG_MAG_LIM)) &&
                         (fy > -35'(DEG_MAG_LIM)) && (fy < 35'(DEG_MAG_LIM));
            sqx_reg   <= fx16 * fx16;
            sqy_reg   <= fy16 * fy16;
            degen_reg <= small_reg &&
                         ((33'(unsigned'(sqx_reg)) + 33'(unsigned'(sqy_reg))) <= DEG_SUM_MAX);
        end
    end

    assign degen = degen_reg;

endmodule

// ===== rtl/hett_cordic.sv =====
// pipelined vectoring cordic: half-plane turn, three normalize stages, one stage per iteration
// depends on hett_pkg
module hett_cordic #(
    parameter int STAGES = hett_pkg::CORDIC_STAGES_DEF
) (
    input  logic          clk,
    input  logic          en,
    input  hett_pkg::cord_t in_y,
    input  hett_pkg::cord_t in_x,
    output hett_pkg::zang_t z_out
);
    import hett_pkg::*;

    // half-plane turn
    cord_t          x0, y0;
    zang_t          z0;
    logic [MW-1:0]  ax, ay, m0;
    cord_t          xp_reg, yp_reg;
    zang_t          zp_reg;
    logic [MW-1:0]  mp_reg;
    logic           zerop_reg;

    always_comb
    begin
        if (in_x[CW-1])
        begin
            x0 = -in_x;
            y0 = -in_y;
            z0 = in_y[CW-1] ? -PI_Q30 : PI_Q30;
        end
        else
        begin
            x0 = in_x;
            y0 = in_y;
            z0 = '0;
        end
        ax = x0[MW-1:0];
        ay = y0[CW-1] ? MW'(-y0) : y0[MW-1:0];
        m0 = (ax > ay) ? ax : ay;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xp_reg    <= x0;
            yp_reg    <= y0;
            zp_reg    <= z0;
            mp_reg    <= m0;
            zerop_reg <= (m0 == '0);
        end
    end

    // normalize: shift left until the larger magnitude reaches 2^40
    cord_t         xn_reg [1:3];
    cord_t         yn_reg [1:3];
    zang_t         zn_reg [1:3];
    logic [MW-1:0] mn_reg [1:3];
    logic          zeron_reg [1:3];

    for (genvar g = 0; g < 3; g++)
    begin : g_norm
        localparam int K1 = 32 >> (2 * g);
        localparam int K2 = K1 / 2;
        cord_t         xi, yi, xa, ya;
        zang_t         zi;
        logic [MW-1:0] mi, ma;
        logic          zeroi;

        if (g == 0)
        begin : g_src
            assign xi = xp_reg;
            assign yi = yp_reg;
            assign zi = zp_reg;
            assign mi = mp_reg;
            assign zeroi = zerop_reg;
        end
        else
        begin : g_src
            assign xi = xn_reg[g];
            assign yi = yn_reg[g];
            assign zi = zn_reg[g];
            assign mi = mn_reg[g];
            assign zeroi = zeron_reg[g];
        end

        always_comb
        begin
            xa = xi;
            ya = yi;
            ma = mi;
            if (ma < (MW'(1) << (MW - K1)))
            begin
                ma = ma << K1;
                xa = xa <<< K1;
                ya = ya <<< K1;
            end
            if (ma < (MW'(1) << (MW - K2)))
            begin
                ma = ma << K2;
                xa = xa <<< K2;
                ya = ya <<< K2;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xn_reg[g+1]    <= xa;
                yn_reg[g+1]    <= ya;
                zn_reg[g+1]    <= zi;
                mn_reg[g+1]    <= ma;
                zeron_reg[g+1] <= zeroi;
            end
        end
    end

    // rotation iterations
    cord_t xc_reg [1:STAGES];
    cord_t yc_reg [1:STAGES];
    zang_t zc_reg [1:STAGES];
    logic  zeroc_reg [1:STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam zang_t ATAN = zang_t'(atan_q30(i));
        cord_t xi, yi;
        zang_t zi;
        logic  zeroi;

        if (i == 0)
        begin : g_src
            assign xi = xn_reg[3];
            assign yi = yn_reg[3];
            assign zi = zn_reg[3];
            assign zeroi = zeron_reg[3];
        end
        else
        begin : g_src
            assign xi = xc_reg[i];
            assign yi = yc_reg[i];
            assign zi = zc_reg[i];
            assign zeroi = zeroc_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!yi[CW-1])
                begin
                    xc_reg[i+1] <= xi + (yi >>> i);
                    yc_reg[i+1] <= yi - (xi >>> i);
                    zc_reg[i+1] <= zi + ATAN;
                end
                else
                begin
                    xc_reg[i+1] <= xi - (yi >>> i);
                    yc_reg[i+1] <= yi + (xi >>> i);
                    zc_reg[i+1] <= zi - ATAN;
                end
                zeroc_reg[i+1] <= zeroi;
            end
        end
    end

    // a zero vector has angle zero
    assign z_out = zeroc_reg[STAGES] ? '0 : zc_reg[STAGES];

endmodule

// ===== rtl/hett_post.sv =====
// back end: angle difference, wrap, magnitude, rounding and limit compare
// depends on hett_pkg
module hett_post #(
    parameter int ANGLE_FRAC_BITS = hett_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              en,
    input  hett_pkg::zang_t     z_target,
    input  hett_pkg::zang_t     z_heading,
    input  hett_pkg::hett_flags_t flags,
    input  logic [14:0]       max_err,
    output logic [14:0]       yaw_error,
    output logic              exceeds_limit,
    output hett_pkg::hett_flags_t flags_out
);
    import hett_pkg::*;

    localparam int          SH   = 30 - ANGLE_FRAC_BITS;
    localparam logic [33:0] HALF = 34'(1) << (SH - 1);

    diff_t        diff_reg;
    hett_flags_t  f1_reg, f2_reg, f3_reg;
    logic [32:0]  mag_reg;
    logic [14:0]  yaw_reg;
    logic         exc_reg;

    diff_t        wrapped;
    logic [32:0]  mag_next;
    logic [33:0]  rsum, rq;
    logic [14:0]  yaw_next;

    always_comb
    begin
        if (diff_reg > PI_DIFF)
            wrapped = diff_reg - TWO_PI_DIFF;
        else if (diff_reg < -PI_DIFF)
            wrapped = diff_reg + TWO_PI_DIFF;
        else
            wrapped = diff_reg;
        if (f1_reg.coin)
            mag_next = '0;
        else if (f1_reg.degen)
            mag_next = 33'(PI_DIFF);
        else
            mag_next = wrapped[ZW] ? 33'(-wrapped) : 33'(wrapped);
    end

    always_comb
    begin
        rsum     = 34'(mag_reg) + HALF;
        rq       = rsum >> SH;
        yaw_next = (rq > 34'(OUT_MAX)) ? OUT_MAX : rq[14:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_t'(z_target) - diff_t'(z_heading);
            f1_reg   <= flags;
            mag_reg  <= mag_next;
            f2_reg   <= f1_reg;
            yaw_reg  <= yaw_next;
            exc_reg  <= yaw_next > max_err;
            f3_reg   <= f2_reg;
        end
    end

    assign yaw_error     = yaw_reg;
    assign exceeds_limit = exc_reg;
    assign flags_out     = f3_reg;

endmodule

// ===== rtl/heading_error_to_target_unit.sv =====
// top level of the heading error unit: front end, two cordic pipelines, back end
// depends on hett_pkg, hett_if, hett_prep, hett_degen, hett_cordic, hett_post
//
// usage:
//   item   - input words: position, target point and rotation quaternion
//   result - one result word per input word: absolute heading error,
//            over-limit flag, coincident-target and degenerate-heading flags
//   cfg    - write of max_yaw_error, always ready; write it only while idle
// latency: CORDIC_STAGES + 9 cycles from accepted input word to result valid
//   (25 at the default); two front-end stages, one half-plane turn, three
//   normalize stages, one stage per cordic iteration, three back-end stages
// throughput: one word per cycle; the two atan2 evaluations run side by side
//   in their own unrolled cordic pipelines
// reset clears every valid bit and loads max_yaw_error with 819
// when the receiver stalls a full output register, the whole pipeline holds
//   and item.ready drops in the same cycle; bubbles still move while the
//   output register is empty or taken
module heading_error_to_target_unit #(
    parameter int CORDIC_STAGES   = hett_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = hett_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    hett_item_if.sink    item,
    hett_result_if.source result,
    hett_cfg_if.sink     cfg
);
    import hett_pkg::*;

    localparam int CL    = CORDIC_STAGES + 4;
    localparam int TOTAL = CL + 5;

    logic               en;
    logic [TOTAL:1]     v_reg;
    logic [14:0]        max_err_reg;

    logic signed [32:0] dx, dy;
    logic signed [34:0] fx, fy;
    logic               coin, degen;
    zang_t              z_target, z_heading;
    logic [CL:1]        coin_d_reg;
    logic [CL-2:1]      degen_d_reg;
    hett_flags_t        flags, flags_out;

    assign en         = !v_reg[TOTAL] || result.ready;
    assign item.ready = en;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[TOTAL-1:1], item.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_err_reg <= MAX_ERR_RESET;
        else if (cfg.valid)
            max_err_reg <= cfg.data;
    end

    hett_prep u_prep (
        .clk      (clk),
        .en       (en),
        .pos_x    (item.pos_x),
        .pos_y    (item.pos_y),
        .target_x (item.target_x),
        .target_y (item.target_y),
        .quat_w   (item.quat_w),
        .quat_x   (item.quat_x),
        .quat_y   (item.quat_y),
        .quat_z   (item.quat_z),
        .dx       (dx),
        .dy       (dy),
        .fx       (fx),
        .fy       (fy),
        .coin     (coin)
    );

    hett_degen u_degen (
        .clk   (clk),
        .en    (en),
        .fx    (fx),
        .fy    (fy),
        .degen (degen)
    );

    // desired heading atan2(-dx, dy)
    hett_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_target (
        .clk   (clk),
        .en    (en),
        .in_y  (-cord_t'(dx)),
        .in_x  (cord_t'(dy)),
        .z_out (z_target)
    );

    // actual heading atan2(-fx, fy)
    hett_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_heading (
        .clk   (clk),
        .en    (en),
        .in_y  (-cord_t'(fx)),
        .in_x  (cord_t'(fy)),
        .z_out (z_heading)
    );

    // flags ride alongside the cordic pipelines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coin_d_reg  <= {coin_d_reg[CL-1:1], coin};
            degen_d_reg <= {degen_d_reg[CL-3:1], degen};
        end
    end

    assign flags.coin  = coin_d_reg[CL];
    assign flags.degen = degen_d_reg[CL-2];

    hett_post #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_post (
        .clk           (clk),
        .en            (en),
        .z_target      (z_target),
        .z_heading     (z_heading),
        .flags         (flags),
        .max_err       (max_err_reg),
        .yaw_error     (result.yaw_error),
        .exceeds_limit (result.exceeds_limit),
        .flags_out     (flags_out)
    );

    assign result.valid              = v_reg[TOTAL];
    assign result.target_coincident  = flags_out.coin;
    // a coincident target skips the heading test
    assign result.heading_degenerate = flags_out.degen && !flags_out.coin;

endmodule

// ===== rtl/hett_check.sv =====
// port-level checks of the heading error unit, bound to its top level
// depends on heading_error_to_target_unit_defines.svh
`include "heading_error_to_target_unit_defines.svh"

module hett_check (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] yaw_error,
    input logic        exceeds_limit,
    input logic        target_coincident,
    input logic        heading_degenerate
);

    `HETT_ASSERT_NXT(a_hold_valid, out_valid && !out_ready, out_valid)
    `HETT_ASSERT_NXT(a_hold_error, out_valid && !out_ready, $stable(yaw_error))
    `HETT_ASSERT_IMP(a_coin_zero, out_valid && target_coincident, yaw_error == 15'd0 && !exceeds_limit && !heading_degenerate)
    `HETT_ASSERT_IMP(a_exceed_nonzero, out_valid && exceeds_limit, yaw_error != 15'd0)

endmodule

bind heading_error_to_target_unit hett_check u_hett_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .yaw_error          (result.yaw_error),
    .exceeds_limit      (result.exceeds_limit),
    .target_coincident  (result.target_coincident),
    .heading_degenerate (result.heading_degenerate)
);

// ===== bench/heading_error_to_target_unit_tb.sv =====
// self-checking bench of the heading error unit: random and corner position, target and
// quaternion words, predicted in-bench and compared with every result word
// depends on hett_pkg, hett_if and heading_error_to_target_unit
`timescale 1ns / 1ps

module heading_error_to_target_unit_tb;

    typedef struct {
        logic signed [31:0] px, py, tx, ty;
        logic signed [15:0] qw, qx, qy, qz;
    } pose_word_t;

    typedef struct {
        logic [14:0] yaw;
        logic        over;
        logic        coin;
        logic        degen;
    } heading_word_t;

    localparam longint PI_Q = 64'sd3373259426;
    localparam longint TWO_PI_Q = 64'sd6746518852;
    localparam longint NORM_LIM = 64'sd1 << 40;
    localparam int     STAGES = hett_pkg::CORDIC_STAGES_DEF;
    localparam int     FRAC = hett_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int     LATENCY = STAGES + 9;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    hett_item_if   item ();
    hett_result_if result ();
    hett_cfg_if    cfg ();

    heading_error_to_target_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    pose_word_t    pose_queue[$];
    heading_word_t heading_expected[$];
    logic [14:0]   yaw_limit;
    int            mismatches;
    longint        cycles;
    bit            no_idle;
    bit            sink_hold;
    bit            src_pause;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint arctan_step(input int i);
        longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                          16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                          262143, 131071, 65535, 32767, 16383, 8191,
                          4095, 2047, 1023, 511, 255, 127};
        return t[i];
    endfunction

    function automatic longint abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // vectoring atan2 in q30 radians, arithmetic shifts floor negatives
    function automatic longint vector_angle(input longint y_in, input longint x_in);
        longint x, y, z, m, xs, ys;
        x = x_in;
        y = y_in;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q : -PI_Q;
            x = -x;
            y = -y;
        end
        m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
        if (m == 0)
            return z;
        while (m < NORM_LIM)
        begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end
        end
        return z;
    endfunction

    function automatic heading_word_t heading_error(input pose_word_t p, input logic [14:0] lim);
        heading_word_t r;
        longint dx, dy, fx, fy, err, ye;
        bit degen;
        dx = longint'(p.tx) - longint'(p.px);
        dy = longint'(p.ty) - longint'(p.py);
        r = '{15'd0, 1'b0, 1'b0, 1'b0};
        if (abs64(dx) < 7 && abs64(dy) < 7 && dx * dx + dy * dy <= 42)
        begin
            r.coin = 1'b1;
            return r;
        end
        fx = 2 * (longint'(p.qx) * p.qy - longint'(p.qw) * p.qz);
        fy = (64'sd1 << 28) - 2 * (longint'(p.qx) * p.qx + longint'(p.qz) * p.qz);
        degen = abs64(fx) < 26844 && abs64(fy) < 26844 && fx * fx + fy * fy <= 720575940;
        if (degen)
            err = PI_Q;
        else
        begin
            err = vector_angle(-dx, dy) - vector_angle(-fx, fy);
            if (err > PI_Q)
                err = err - TWO_PI_Q;
            else if (err < -PI_Q)
                err = err + TWO_PI_Q;
            err = abs64(err);
        end
        ye = (err + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        if (ye > 32767)
            ye = 32767;
        r.yaw = ye[14:0];
        r.over = ye > longint'(lim);
        r.degen = degen;
        return r;
    endfunction

    // driver: offers the head of the pending queue, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                heading_expected.push_back(heading_error(pose_queue.pop_front(), yaw_limit));
            end
            if ((!item.valid || item.ready) )
            begin
                if (pose_queue.size() > 0 && !src_pause
                    && (no_idle || $urandom_range(99) >= 30))
                begin
                    pose_word_t n;
                    n = pose_queue[0];
                    item.valid <= 1'b1;
                    item.pos_x <= n.px;
                    item.pos_y <= n.py;
                    item.target_x <= n.tx;
                    item.target_y <= n.ty;
                    item.quat_w <= n.qw;
                    item.quat_x <= n.qx;
                    item.quat_y <= n.qy;
                    item.quat_z <= n.qz;
                end
                else
                    item.valid <= 1'b0;
            end
        end
    end

    // monitor: result ready idles at random, or holds off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (heading_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word yaw=%0d", result.yaw_error);
                end
                else
                begin
                    heading_word_t e;
                    e = heading_expected.pop_front();
                    if (result.yaw_error !== e.yaw || result.exceeds_limit !== e.over
                        || result.target_coincident !== e.coin
                        || result.heading_degenerate !== e.degen)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp yaw=%0d over=%0b coin=%0b degen=%0b, ",
                                     "got yaw=%0d over=%0b coin=%0b degen=%0b",
                                     e.yaw, e.over, e.coin, e.degen, result.yaw_error,
                                     result.exceeds_limit, result.target_coincident,
                                     result.heading_degenerate);
                    end
                end
            end
            result.ready <= !sink_hold && (no_idle || $urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);
            default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic pose_word_t rand_pose();
        pose_word_t p;
        p.px = $urandom;
        p.py = $urandom;
        case ($urandom_range(3))
            0: begin p.tx = $urandom; p.ty = $urandom; end
            1: begin p.tx = p.px + $signed(32'($urandom_range(12))) - 6;
                     p.ty = p.py + $signed(32'($urandom_range(12))) - 6; end
            default: begin p.tx = p.px + ($signed($urandom) >>> $urandom_range(31));
                           p.ty = p.py + ($signed($urandom) >>> $urandom_range(31)); end
        endcase
        p.qw = rand_quat();
        p.qx = rand_quat();
        p.qy = rand_quat();
        p.qz = rand_quat();
        // occasionally a forward axis close to vertical
        if ($urandom_range(9) == 0)
        begin
            p.qw = 16'sd11585;
            p.qx = 16'sd11585 + $signed(16'($urandom_range(4))) - 2;
            p.qy = $signed(16'($urandom_range(6))) - 3;
            p.qz = $signed(16'($urandom_range(6))) - 3;
        end
        return p;
    endfunction

    task automatic drain();
        wait (pose_queue.size() == 0 && !item.valid && heading_expected.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [14:0] v);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        yaw_limit = v;
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic [14:0] limits[5] = '{15'd0, 15'd25736, 15'd32767, 15'd819, 15'd4000};
        pose_word_t p;
        rst_n = 1'b0;
        cycles = 0;
        mismatches = 0;
        no_idle = 0;
        sink_hold = 0;
        src_pause = 0;
        yaw_limit = hett_pkg::MAX_ERR_RESET;
        cfg.valid = 1'b0;
        cfg.data = '0;
        item.valid = 1'b0;
        item.pos_x = '0;
        item.pos_y = '0;
        item.target_x = '0;
        item.target_y = '0;
        item.quat_w = '0;
        item.quat_x = '0;
        item.quat_y = '0;
        item.quat_z = '0;
        result.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, coincident target, degenerate heading, identity
        pose_queue.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                               16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        pose_queue.push_back('{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                               -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384});
        pose_queue.push_back('{32'sd5, 32'sd5, 32'sd5, 32'sd5, 16'sd16384, 16'sd0, 16'sd0,
                               16'sd0});
        pose_queue.push_back('{32'sd0, 32'sd0, 32'sd6, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pose_queue.push_back('{32'sd0, 32'sd0, 32'sd4, 32'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pose_queue.push_back('{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 16'sd11585, 16'sd11585,
                               16'sd0, 16'sd0});
        pose_queue.push_back('{32'sd0, 32'sd0, -32'sd65536, 32'sd0, 16'sd16384, 16'sd0,
                               16'sd0, 16'sd0});
        pose_queue.push_back('{32'sd0, 32'sd0, 32'sd0, -32'sd65536, 16'sd0, 16'sd0, 16'sd0,
                               16'sd16384});
        pose_queue.push_back('{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 16'shffff, 16'sh8000,
                               16'sh7fff, 16'sh8000});
        for (int i = 0; i < 10; i++)
            pose_queue.push_back(rand_pose());
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_limit(limits[ph]);
            no_idle = (ph == 2);
            for (int i = 0; i < 290; i++)
                pose_queue.push_back(rand_pose());
            if (ph == 1)
            begin
                // hold off the receiver long enough to back the pipeline up
                sink_hold = 1;
                repeat (3 * LATENCY) @(posedge clk);
                sink_hold = 0;
            end
            if (ph == 3)
            begin
                wait (pose_queue.size() < 150);
                src_pause = 1;
                wait (heading_expected.size() == 0 && !item.valid);
                src_pause = 0;
            end
            drain();
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
